[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define TBP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define TBP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/tbp_pkg.sv]
package tbp_pkg;

   localparam int MAX_GLOBAL_BITS  = 13;
   localparam int MAX_BIMODAL_BITS = 12;
   localparam int MAX_CHOOSER_BITS = 12;

   localparam int GSH_W = MAX_GLOBAL_BITS;
   localparam int BIM_W = MAX_BIMODAL_BITS;
   localparam int CHO_W = MAX_CHOOSER_BITS;
   localparam int GSH_DEPTH = 1 << GSH_W;
   localparam int BIM_DEPTH = 1 << BIM_W;
   localparam int CHO_DEPTH = 1 << CHO_W;

   localparam int GB_MAX = (GSH_W > BIM_W) ? GSH_W : BIM_W;
   localparam int CLR_W  = (GB_MAX > CHO_W) ? GB_MAX : CHO_W;

   localparam int ADDR_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_BITS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIMODAL_BITS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHOOSER_BITS = 2'd3;

   localparam logic [1:0] MODE_STATIC     = 2'd0;
   localparam logic [1:0] MODE_GSHARE     = 2'd1;
   localparam logic [1:0] MODE_TOURNAMENT = 2'd2;

   localparam logic [1:0] MODE_RST         = MODE_GSHARE;
   localparam logic [3:0] GLOBAL_BITS_RST  = 4'd13;
   localparam logic [3:0] BIMODAL_BITS_RST = 4'd10;
   localparam logic [3:0] CHOOSER_BITS_RST = 4'd10;

   localparam logic [1:0] CTR_WEAK_TAKEN     = 2'd2;
   localparam logic [1:0] CTR_WEAK_NOT_TAKEN = 2'd1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

   // low-bit mask of the given width, clamped to 1..maxbits
   function automatic logic [CLR_W-1:0] width_mask(logic [3:0] bits, int maxbits);
      int eff;
      logic [CLR_W-1:0] m;
      eff = int'(bits);
      if (eff < 1) eff = 1;
      if (eff > maxbits) eff = maxbits;
      for (int i = 0; i < CLR_W; i++) begin
         m[i] = (i < eff);
      end
      return m;
   endfunction

   function automatic logic [1:0] sat_update(logic [1:0] c, logic t);
      logic [1:0] r;
      if (t) r = (c == 2'd3) ? 2'd3 : c + 2'd1;
      else   r = (c == 2'd0) ? 2'd0 : c - 2'd1;
      return r;
   endfunction

endpackage

[rtl/tbp_req_if.sv]
interface tbp_req_if;
   logic                         valid;
   logic                         ready;
   logic [tbp_pkg::ADDR_W-1:0]   branch_addr;
   logic                         taken;

   modport source (output valid, output branch_addr, output taken, input ready);
   modport sink   (input valid, input branch_addr, input taken, output ready);
endinterface

[rtl/tbp_rsp_if.sv]
interface tbp_rsp_if;
   logic valid;
   logic ready;
   logic predict_taken;

   modport source (output valid, output predict_taken, input ready);
   modport sink   (input valid, input predict_taken, output ready);
endinterface

[rtl/tournament_branch_predictor.sv]
// a result is registered from the write state that follows an accepted item, once the output is free
// the block takes no new item until the last is written back; the registered table read is followed by a
// read-modify-write on the gshare, bimodal and chooser counter memories, as the mode trains
// reset: synchronous, active high; afterwards a sweep reloads the counter tables while
// req ready stays low; csr writes are taken during the sweep
module tournament_branch_predictor (
   input  logic                            clock,
   input  logic                            reset,
   tbp_req_if.sink                         req_chan,
   tbp_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [tbp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tbp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   tbp_pkg::cmd_type    cmd;
   tbp_pkg::status_type status;

   tbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tbp_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .branch_addr   (req_chan.branch_addr),
      .taken         (req_chan.taken),
      .cmd           (cmd),
      .status        (status),
      .predict_taken (rsp_chan.predict_taken)
   );

endmodule

[rtl/tbp_datapath.sv]
module tbp_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [tbp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tbp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [tbp_pkg::ADDR_W-1:0]         branch_addr,
   input  logic                               taken,
   input  tbp_pkg::cmd_type                   cmd,
   output tbp_pkg::status_type                status,
   output logic                               predict_taken
);

   logic [1:0] mode_ff;
   logic [3:0] global_bits_ff;
   logic [3:0] bimodal_bits_ff;
   logic [3:0] chooser_bits_ff;

   logic [tbp_pkg::GSH_W-1:0] hist_ff;
   logic [tbp_pkg::CLR_W-1:0] clr_cnt_ff;

   logic [1:0] gsh_mem [tbp_pkg::GSH_DEPTH];
   logic [1:0] bim_mem [tbp_pkg::BIM_DEPTH];
   logic [1:0] cho_mem [tbp_pkg::CHO_DEPTH];

   logic [1:0] gsh_rd_ff, bim_rd_ff, cho_rd_ff;
   logic [tbp_pkg::GSH_W-1:0] gi_ff;
   logic [tbp_pkg::BIM_W-1:0] bi_ff;
   logic [tbp_pkg::CHO_W-1:0] ci_ff;
   logic                      taken_ff;
   logic                      pred_ff;

   logic [tbp_pkg::CLR_W-1:0] gmask, bmask, cmask;
   logic [tbp_pkg::GSH_W-1:0] gi_acc;
   logic [tbp_pkg::BIM_W-1:0] bi_acc;
   logic [tbp_pkg::CHO_W-1:0] ci_acc;

   logic gp, bp, pred;
   logic gsh_train, tour_train, cho_train;
   logic gsh_we, bim_we, cho_we;
   logic [tbp_pkg::GSH_W-1:0] gsh_waddr;
   logic [tbp_pkg::BIM_W-1:0] bim_waddr;
   logic [tbp_pkg::CHO_W-1:0] cho_waddr;
   logic [1:0] gsh_wdata, bim_wdata, cho_wdata;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= tbp_pkg::MODE_RST;
         global_bits_ff  <= tbp_pkg::GLOBAL_BITS_RST;
         bimodal_bits_ff <= tbp_pkg::BIMODAL_BITS_RST;
         chooser_bits_ff <= tbp_pkg::CHOOSER_BITS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tbp_pkg::CSR_MODE:         mode_ff         <= csr_wdata[1:0];
            tbp_pkg::CSR_GLOBAL_BITS:  global_bits_ff  <= csr_wdata;
            tbp_pkg::CSR_BIMODAL_BITS: bimodal_bits_ff <= csr_wdata;
            tbp_pkg::CSR_CHOOSER_BITS: chooser_bits_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // table indices formed from the incoming item
   always_comb begin
      gmask  = tbp_pkg::width_mask(global_bits_ff, tbp_pkg::MAX_GLOBAL_BITS);
      bmask  = tbp_pkg::width_mask(bimodal_bits_ff, tbp_pkg::MAX_BIMODAL_BITS);
      cmask  = tbp_pkg::width_mask(chooser_bits_ff, tbp_pkg::MAX_CHOOSER_BITS);
      gi_acc = (branch_addr[tbp_pkg::GSH_W-1:0] ^ hist_ff) & gmask[tbp_pkg::GSH_W-1:0];
      bi_acc = branch_addr[tbp_pkg::BIM_W-1:0] & bmask[tbp_pkg::BIM_W-1:0];
      ci_acc = branch_addr[tbp_pkg::CHO_W-1:0] & cmask[tbp_pkg::CHO_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         gi_ff    <= gi_acc;
         bi_ff    <= bi_acc;
         ci_ff    <= ci_acc;
         taken_ff <= taken;
      end
   end

   // prediction and training from the registered table reads
   always_comb begin
      gp = gsh_rd_ff[1];
      bp = bim_rd_ff[1];
      gsh_train  = 1'b0;
      tour_train = 1'b0;
      unique case (mode_ff)
         tbp_pkg::MODE_STATIC: pred = 1'b1;
         tbp_pkg::MODE_GSHARE: begin
            pred      = gp;
            gsh_train = 1'b1;
         end
         tbp_pkg::MODE_TOURNAMENT: begin
            pred       = cho_rd_ff[1] ? gp : bp;
            gsh_train  = 1'b1;
            tour_train = 1'b1;
         end
         default: pred = 1'b0;
      endcase
      cho_train = tour_train && (gp != bp);
   end

   always_comb begin
      gsh_we    = cmd.clear || (cmd.commit && gsh_train);
      bim_we    = cmd.clear || (cmd.commit && tour_train);
      cho_we    = cmd.clear || (cmd.commit && cho_train);
      gsh_waddr = cmd.clear ? clr_cnt_ff[tbp_pkg::GSH_W-1:0] : gi_ff;
      bim_waddr = cmd.clear ? clr_cnt_ff[tbp_pkg::BIM_W-1:0] : bi_ff;
      cho_waddr = cmd.clear ? clr_cnt_ff[tbp_pkg::CHO_W-1:0] : ci_ff;
      gsh_wdata = cmd.clear ? tbp_pkg::CTR_WEAK_TAKEN
                            : tbp_pkg::sat_update(gsh_rd_ff, taken_ff);
      bim_wdata = cmd.clear ? tbp_pkg::CTR_WEAK_TAKEN
                            : tbp_pkg::sat_update(bim_rd_ff, taken_ff);
      cho_wdata = cmd.clear ? tbp_pkg::CTR_WEAK_NOT_TAKEN
                            : tbp_pkg::sat_update(cho_rd_ff, gp == taken_ff);
   end

   always_ff @(posedge clock) begin
      if (gsh_we) gsh_mem[gsh_waddr] <= gsh_wdata;
      if (cmd.capture) gsh_rd_ff <= gsh_mem[gi_acc];
   end

   always_ff @(posedge clock) begin
      if (bim_we) bim_mem[bim_waddr] <= bim_wdata;
      if (cmd.capture) bim_rd_ff <= bim_mem[bi_acc];
   end

   always_ff @(posedge clock) begin
      if (cho_we) cho_mem[cho_waddr] <= cho_wdata;
      if (cmd.capture) cho_rd_ff <= cho_mem[ci_acc];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff    <= '0;
         clr_cnt_ff <= '0;
      end else begin
         if (cmd.clear) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (cmd.commit && gsh_train) hist_ff <= tbp_pkg::GSH_W'({hist_ff, taken_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) pred_ff <= pred;
   end

   assign status.clear_last = (clr_cnt_ff == '1);
   assign predict_taken     = pred_ff;

endmodule

[rtl/tbp_ctrl.sv]
`include "assert_macros.svh"

module tbp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tbp_pkg::status_type  status,
   output tbp_pkg::cmd_type     cmd
);

   tbp_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, out_free;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tbp_pkg::ST_CLEAR: if (status.clear_last) state_in = tbp_pkg::ST_IDLE;
         tbp_pkg::ST_IDLE:  if (accept) state_in = tbp_pkg::ST_WRITE;
         tbp_pkg::ST_WRITE: if (out_free) state_in = tbp_pkg::ST_IDLE;
         default:           state_in = tbp_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.clear   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         tbp_pkg::ST_CLEAR: cmd.clear = 1'b1;
         tbp_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         tbp_pkg::ST_WRITE: cmd.commit = out_free;
         default: ;
      endcase
   end

   // output slot: a new item lands when the old one leaves or the slot is empty
   always_comb begin
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbp_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `TBP_ASSERT_ALWAYS(a_reset_clears, reset |=> (state_ff == tbp_pkg::ST_CLEAR), "reset must start the table sweep")
   `TBP_ASSERT(a_accept_to_write, accept |=> (state_ff == tbp_pkg::ST_WRITE), "accepted item must go to write-back")
   `TBP_ASSERT(a_no_overwrite, (rsp_valid_ff && !rsp_ready) |-> !cmd.commit, "held result overwritten")
   `TBP_ASSERT(a_rsp_from_write, $rose(rsp_valid_ff) |-> $past(state_ff == tbp_pkg::ST_WRITE), "result without write-back")

endmodule

[bench/tournament_branch_predictor_test.sv]
module tournament_branch_predictor_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int POOL_SIZE = 8;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [tbp_pkg::CSR_IDX_W-1:0] csr_index;
   logic [tbp_pkg::CSR_DATA_W-1:0] csr_wdata;

   tbp_req_if req_chan ();
   tbp_rsp_if rsp_chan ();

   tournament_branch_predictor u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("[tournament_branch_predictor] ERROR");
      $finish;
   end

   // predictor state and register copies
   logic [1:0] gshare_ctr [tbp_pkg::GSH_DEPTH];
   logic [1:0] bimodal_ctr [tbp_pkg::BIM_DEPTH];
   logic [1:0] chooser_ctr [tbp_pkg::CHO_DEPTH];
   logic [tbp_pkg::GSH_W-1:0] path_history;
   logic [1:0] mode_cfg;
   logic [3:0] gbits_cfg;
   logic [3:0] bbits_cfg;
   logic [3:0] cbits_cfg;

   logic expected_predictions [$];
   int mismatch_count = 0;
   int results_seen = 0;
   bit no_idle = 1'b0;

   // pool of hot branches for the random part
   logic [tbp_pkg::ADDR_W-1:0] hot_addr [POOL_SIZE];
   int hot_bias [POOL_SIZE];
   int hot_visits [POOL_SIZE];

   function automatic logic [tbp_pkg::GSH_W-1:0] low_mask(logic [3:0] bits, int maxb);
      int eff;
      eff = int'(bits);
      if (eff < 1) eff = 1;
      if (eff > maxb) eff = maxb;
      return tbp_pkg::GSH_W'((1 << eff) - 1);
   endfunction

   function automatic logic [1:0] step_counter(logic [1:0] c, logic up);
      if (up) return (c == 2'd3) ? 2'd3 : c + 2'd1;
      return (c == 2'd0) ? 2'd0 : c - 2'd1;
   endfunction

   function automatic void reset_model();
      foreach (gshare_ctr[i]) gshare_ctr[i] = tbp_pkg::CTR_WEAK_TAKEN;
      foreach (bimodal_ctr[i]) bimodal_ctr[i] = tbp_pkg::CTR_WEAK_TAKEN;
      foreach (chooser_ctr[i]) chooser_ctr[i] = tbp_pkg::CTR_WEAK_NOT_TAKEN;
      path_history = '0;
      mode_cfg = tbp_pkg::MODE_RST;
      gbits_cfg = tbp_pkg::GLOBAL_BITS_RST;
      bbits_cfg = tbp_pkg::BIMODAL_BITS_RST;
      cbits_cfg = tbp_pkg::CHOOSER_BITS_RST;
   endfunction

   // prediction from the current tables, then training on the outcome
   function automatic logic predict_branch(logic [tbp_pkg::ADDR_W-1:0] addr, logic outcome);
      logic [tbp_pkg::GSH_W-1:0] gi;
      logic [tbp_pkg::BIM_W-1:0] bi;
      logic [tbp_pkg::CHO_W-1:0] ci;
      logic g_dir;
      logic b_dir;
      logic dir;
      gi = (addr[tbp_pkg::GSH_W-1:0] ^ path_history)
           & low_mask(gbits_cfg, tbp_pkg::MAX_GLOBAL_BITS);
      bi = addr[tbp_pkg::BIM_W-1:0]
           & tbp_pkg::BIM_W'(low_mask(bbits_cfg, tbp_pkg::MAX_BIMODAL_BITS));
      ci = addr[tbp_pkg::CHO_W-1:0]
           & tbp_pkg::CHO_W'(low_mask(cbits_cfg, tbp_pkg::MAX_CHOOSER_BITS));
      g_dir = gshare_ctr[gi] >= 2'd2;
      b_dir = bimodal_ctr[bi] >= 2'd2;
      case (mode_cfg)
         tbp_pkg::MODE_STATIC: begin
            dir = 1'b1;
         end
         tbp_pkg::MODE_GSHARE: begin
            dir = g_dir;
            gshare_ctr[gi] = step_counter(gshare_ctr[gi], outcome);
            path_history = {path_history[tbp_pkg::GSH_W-2:0], outcome};
         end
         tbp_pkg::MODE_TOURNAMENT: begin
            dir = (chooser_ctr[ci] >= 2'd2) ? g_dir : b_dir;
            if (g_dir != b_dir) chooser_ctr[ci] = step_counter(chooser_ctr[ci], g_dir == outcome);
            gshare_ctr[gi] = step_counter(gshare_ctr[gi], outcome);
            bimodal_ctr[bi] = step_counter(bimodal_ctr[bi], outcome);
            path_history = {path_history[tbp_pkg::GSH_W-2:0], outcome};
         end
         default: begin
            dir = 1'b0;
         end
      endcase
      return dir;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic send_branch(input logic [tbp_pkg::ADDR_W-1:0] addr, input logic outcome);
      int gap;
      gap = idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.branch_addr <= addr;
      req_chan.taken <= outcome;
      do @(posedge clock); while (!req_chan.ready);
      expected_predictions.push_back(predict_branch(addr, outcome));
   endtask

   task automatic release_bus();
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_predictions.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [tbp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tbp_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         tbp_pkg::CSR_MODE:         mode_cfg = data[1:0];
         tbp_pkg::CSR_GLOBAL_BITS:  gbits_cfg = data;
         tbp_pkg::CSR_BIMODAL_BITS: bbits_cfg = data;
         tbp_pkg::CSR_CHOOSER_BITS: cbits_cfg = data;
         default: ;
      endcase
   endtask

   // block must be idle: bus released and every result back
   task automatic set_config(input logic [3:0] mode_word, input logic [3:0] gbits,
                             input logic [3:0] bbits, input logic [3:0] cbits);
      release_bus();
      wait_drained();
      write_reg(tbp_pkg::CSR_MODE, mode_word);
      write_reg(tbp_pkg::CSR_GLOBAL_BITS, gbits);
      write_reg(tbp_pkg::CSR_BIMODAL_BITS, bbits);
      write_reg(tbp_pkg::CSR_CHOOSER_BITS, cbits);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (expected_predictions.size() == 0) begin
            report_mismatch($sformatf("result %0d with no item pending", results_seen));
         end else begin
            logic want;
            want = expected_predictions.pop_front();
            if (rsp_chan.predict_taken !== want)
               report_mismatch($sformatf("result %0d predict_taken %b, expected %b",
                                         results_seen, rsp_chan.predict_taken, want));
         end
      end
   end

   // result side back-pressure
   initial begin
      int hold;
      hold = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else if (rsp_chan.ready && !no_idle && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            hold = idle_len();
         end else begin
            rsp_chan.ready <= 1'b1;
            hold = $urandom_range(0, 8);
         end
      end
   end

   task automatic test_default_gshare();
      send_branch(32'h0000_0000, 1'b0);
      send_branch(32'hFFFF_FFFF, 1'b1);
      send_branch(32'h0000_0000, 1'b1);
      send_branch(32'h5555_AAAA, 1'b0);
   endtask

   task automatic test_static_mode();
      set_config({2'b00, tbp_pkg::MODE_STATIC}, 4'd13, 4'd10, 4'd10);
      send_branch(32'hFFFF_FFFF, 1'b0);
      send_branch(32'h0000_0000, 1'b0);
      send_branch(32'h1234_5678, 1'b1);
   endtask

   task automatic test_spare_mode();
      set_config({2'b11, MODE_SPARE}, 4'd13, 4'd10, 4'd10);
      send_branch(32'hAAAA_5555, 1'b1);
      send_branch(32'h0000_0000, 1'b0);
   endtask

   // zero width acts as one, oversize width as the maximum
   task automatic test_tournament_saturation();
      set_config({2'b00, tbp_pkg::MODE_TOURNAMENT}, 4'd0, 4'd15, 4'd15);
      repeat (3) send_branch(32'h0000_0F0F, 1'b1);
      repeat (3) send_branch(32'h0000_0F0F, 1'b0);
   endtask

   task automatic test_width_limits();
      set_config({2'b00, tbp_pkg::MODE_TOURNAMENT}, 4'd15, 4'd0, 4'd0);
      send_branch(32'hFFFF_FFFE, 1'b0);
      send_branch(32'h0000_0001, 1'b1);
      send_branch(32'hFFFF_FFFF, 1'b0);
      send_branch(32'h8000_0000, 1'b1);
      set_config({2'b00, tbp_pkg::MODE_GSHARE}, 4'd1, 4'd12, 4'd12);
      send_branch(32'h7FFF_FFFF, 1'b1);
      send_branch(32'h0000_1FFF, 1'b0);
      send_branch(32'hFFFF_E000, 1'b1);
   endtask

   function automatic logic [3:0] pick_width(int maxb);
      case ($urandom_range(0, 9))
         0: return 4'd0;
         1: return 4'(maxb);
         2: return 4'($urandom_range(maxb + 1, 15));
         3: return 4'd1;
         default: return 4'($urandom_range(1, maxb));
      endcase
   endfunction

   function automatic logic [1:0] pick_mode();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return tbp_pkg::MODE_TOURNAMENT;
      if (r < 75) return tbp_pkg::MODE_GSHARE;
      if (r < 88) return tbp_pkg::MODE_STATIC;
      return MODE_SPARE;
   endfunction

   function automatic void refill_pool();
      foreach (hot_addr[i]) begin
         hot_addr[i] = $urandom();
         hot_bias[i] = $urandom_range(0, 3);
         hot_visits[i] = 0;
      end
   endfunction

   // loop-like branch streams with random content, plus some noise
   task automatic test_random_phases();
      int n_items;
      int k;
      logic outcome;
      for (int phase = 0; phase < 8; phase++) begin
         set_config({2'($urandom_range(0, 3)), pick_mode()},
                    pick_width(tbp_pkg::MAX_GLOBAL_BITS),
                    pick_width(tbp_pkg::MAX_BIMODAL_BITS),
                    pick_width(tbp_pkg::MAX_CHOOSER_BITS));
         refill_pool();
         no_idle = (phase == 2);
         n_items = $urandom_range(80, 120);
         for (int n = 0; n < n_items; n++) begin
            if (phase == 4 && n == n_items / 2) begin
               release_bus();
               wait_drained();
            end
            if ($urandom_range(0, 9) < 7) begin
               k = $urandom_range(0, POOL_SIZE - 1);
               case (hot_bias[k])
                  0: outcome = 1'b0;
                  1: outcome = 1'b1;
                  2: outcome = (hot_visits[k] % 4) != 3;
                  default: outcome = $urandom_range(0, 1);
               endcase
               hot_visits[k]++;
               send_branch(hot_addr[k], outcome);
            end else begin
               send_branch($urandom(), $urandom_range(0, 1));
            end
         end
         no_idle = 1'b0;
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.branch_addr = '0;
      req_chan.taken = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = tbp_pkg::CSR_MODE;
      csr_wdata = '0;
      reset = 1'b1;
      reset_model();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_gshare();
      test_static_mode();
      test_spare_mode();
      test_tournament_saturation();
      test_width_limits();
      test_random_phases();

      release_bus();
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[tournament_branch_predictor] OK");
      end else begin
         $display("[tournament_branch_predictor] ERROR");
      end
      $finish;
   end

endmodule
